[hdl/msm_pkg.sv]
// Shared constants and types for the multiprecision scalar multiplier.
package msm_pkg;

  localparam int MAX_LIMBS  = 64;
  localparam int LIMB_BITS  = 28;
  localparam int SCALAR_W   = 32;
  localparam int WORD_W     = 32;
  localparam int LEN_W      = 7;
  localparam int PROD_W     = LIMB_BITS + SCALAR_W;
  localparam int CNT_W      = $clog2(MAX_LIMBS + 2);
  localparam int WIDE_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int S_DATA_W   = 96;
  localparam int M_DATA_W   = 72;

  typedef struct packed {
    logic [WORD_W-1:0] carry;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  extent;
    logic              overflow;
  } msm_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_limb;
    logic              last_out;
    logic [LEN_W-1:0]  result_length;
    logic [WORD_W-1:0] result_sign;
    logic              too_long;
  } msm_result_t;

endpackage

[hdl/multiprecision_scalar_multiply.sv]
// Top level of the multiprecision scalar multiplier with its stream ports.
// A product limb goes through the input register and the result queue before it
// is offered. Throughput: one limb per cycle while the queue has room for two;
// the last limb of a number also queues its carry word; the queue has one output.
// Reset clears the carry chain, the limb counters and the result queue.
module multiprecision_scalar_multiply (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // limb[27:0], scalar[59:28], sign_tag[91:60], zero fill[95:92]
  input  logic [msm_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_limb[31:0], result_length[38:32], result_sign[70:39], zero fill[71]
  output logic [msm_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast,
  // too_long[0]
  output logic                          m_tuser
);

  logic                           in_valid;
  logic [msm_pkg::LIMB_BITS-1:0]  in_limb;
  logic [msm_pkg::SCALAR_W-1:0]   in_scalar;
  logic [msm_pkg::WORD_W-1:0]     in_tag;
  logic                           in_last;
  msm_pkg::msm_state_t            state;
  msm_pkg::msm_state_t            state_next;
  msm_pkg::msm_result_t           product;
  msm_pkg::msm_result_t           final_word;
  msm_pkg::msm_result_t           out_item;
  logic                           room_two;
  logic                           advance;
  logic                           take;

  assign advance  = in_valid && room_two;
  assign s_tready = !in_valid || room_two;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      state    <= '0;
    end else begin
      if (take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_limb   <= s_tdata[27:0];
      in_scalar <= s_tdata[59:28];
      in_tag    <= s_tdata[91:60];
      in_last   <= s_tlast;
    end
  end

  msm_mac u_mac (
    .limb       (in_limb),
    .scalar     (in_scalar),
    .sign_tag   (in_tag),
    .last_limb  (in_last),
    .state      (state),
    .state_next (state_next),
    .product    (product),
    .final_word (final_word)
  );

  msm_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (advance),
    .item_a    (product),
    .push_b    (in_last),
    .item_b    (final_word),
    .pop       (m_tready),
    .out_valid (m_tvalid),
    .out_item  (out_item),
    .room_two  (room_two)
  );

  assign m_tdata = {1'b0, out_item.result_sign, out_item.result_length, out_item.out_limb};
  assign m_tlast = out_item.last_out;
  assign m_tuser = out_item.too_long;

endmodule

[hdl/msm_mac.sv]
// Multiply-accumulate step: one limb times the scalar plus the running carry.
module msm_mac (
  input  logic [msm_pkg::LIMB_BITS-1:0] limb,
  input  logic [msm_pkg::SCALAR_W-1:0]  scalar,
  input  logic [msm_pkg::WORD_W-1:0]    sign_tag,
  input  logic                          last_limb,
  input  msm_pkg::msm_state_t           state,
  output msm_pkg::msm_state_t           state_next,
  output msm_pkg::msm_result_t          product,
  output msm_pkg::msm_result_t          final_word
);

  logic [msm_pkg::PROD_W-1:0]    sum;
  logic [msm_pkg::LIMB_BITS-1:0] plimb;
  logic [msm_pkg::WORD_W-1:0]    carry_n;
  logic                          ovf;
  logic [msm_pkg::CNT_W-1:0]     pos_n;
  logic [msm_pkg::CNT_W-1:0]     ext_n;
  logic [msm_pkg::WIDE_W-1:0]    len;

  assign sum     = msm_pkg::PROD_W'(limb) * msm_pkg::PROD_W'(scalar)
                 + msm_pkg::PROD_W'(state.carry);
  assign plimb   = sum[msm_pkg::LIMB_BITS-1:0];
  assign carry_n = sum[msm_pkg::PROD_W-1:msm_pkg::LIMB_BITS];
  assign ovf     = state.overflow
                 || (state.pos >= msm_pkg::CNT_W'(msm_pkg::MAX_LIMBS));

  always_comb begin
    pos_n = state.pos;
    ext_n = state.extent;
    if (!ovf) begin
      pos_n = state.pos + msm_pkg::CNT_W'(1);
      if (plimb != '0) begin
        ext_n = pos_n;
      end
    end
  end

  always_comb begin
    if (ovf) begin
      len = '0;
    end else if (carry_n != '0) begin
      len = msm_pkg::WIDE_W'(pos_n) + msm_pkg::WIDE_W'(1);
    end else begin
      len = msm_pkg::WIDE_W'(ext_n);
    end
  end

  always_comb begin
    product.out_limb      = msm_pkg::WORD_W'(plimb);
    product.last_out      = 1'b0;
    product.result_length = '0;
    product.result_sign   = '0;
    product.too_long      = ovf;

    final_word.out_limb      = carry_n;
    final_word.last_out      = 1'b1;
    final_word.result_length = len[msm_pkg::LEN_W-1:0];
    final_word.result_sign   = (len == '0) ? '0 : sign_tag;
    final_word.too_long      = ovf;

    if (last_limb) begin
      state_next = '0;
    end else begin
      state_next.carry    = carry_n;
      state_next.pos      = pos_n;
      state_next.extent   = ext_n;
      state_next.overflow = ovf;
    end
  end

endmodule

[hdl/msm_result_fifo.sv]
// Small result queue that takes one or two results per cycle and hands out one.
module msm_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_a,
  input  msm_pkg::msm_result_t item_a,
  input  logic                 push_b,
  input  msm_pkg::msm_result_t item_b,
  input  logic                 pop,
  output logic                 out_valid,
  output msm_pkg::msm_result_t out_item,
  output logic                 room_two
);

  msm_pkg::msm_result_t           entries [msm_pkg::FIFO_DEPTH];
  logic [msm_pkg::PTR_W-1:0]      wr_ptr;
  logic [msm_pkg::PTR_W-1:0]      rd_ptr;
  logic [msm_pkg::FCNT_W-1:0]     count;
  logic [msm_pkg::FCNT_W-1:0]     count_next;
  logic [msm_pkg::FCNT_W-1:0]     push_n;
  logic                           do_pop;

  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign room_two  = (count <= msm_pkg::FCNT_W'(msm_pkg::FIFO_DEPTH - 2));
  assign do_pop    = pop && out_valid;

  always_comb begin
    push_n = '0;
    if (push_a) begin
      push_n = push_b ? msm_pkg::FCNT_W'(2) : msm_pkg::FCNT_W'(1);
    end
    count_next = count + push_n - (do_pop ? msm_pkg::FCNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[msm_pkg::PTR_W-1:0];
      if (do_pop) begin
        rd_ptr <= rd_ptr + msm_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wr_ptr] <= item_a;
      if (push_b) begin
        entries[wr_ptr + msm_pkg::PTR_W'(1)] <= item_b;
      end
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the multiprecision scalar multiplier stream block.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [msm_pkg::LIMB_BITS-1:0] limb;
    logic [msm_pkg::SCALAR_W-1:0]  scalar;
    logic [msm_pkg::WORD_W-1:0]    sign_tag;
    logic                          last;
  } limb_item_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [msm_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [msm_pkg::M_DATA_W-1:0] m_tdata;
  logic                         m_tlast;
  logic                         m_tuser;

  msm_pkg::msm_result_t       product_q[$];
  logic [msm_pkg::WORD_W-1:0] carry_acc = '0;
  logic [msm_pkg::LEN_W-1:0]  limbs_taken = '0;
  logic [msm_pkg::LEN_W-1:0]  extent_nz = '0;
  logic                       overflowed = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  multiprecision_scalar_multiply u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic predict_products(input limb_item_t it);
    logic [63:0]               total;
    logic [msm_pkg::LEN_W-1:0] len;
    msm_pkg::msm_result_t      r;
    total = 64'(it.limb) * 64'(it.scalar) + 64'(carry_acc);
    carry_acc = total[msm_pkg::LIMB_BITS +: msm_pkg::WORD_W];
    if (limbs_taken >= msm_pkg::MAX_LIMBS) begin
      overflowed = 1'b1;
    end else begin
      if (total[msm_pkg::LIMB_BITS-1:0] != '0) extent_nz = limbs_taken + 1'b1;
      limbs_taken = limbs_taken + 1'b1;
    end
    r = '0;
    r.out_limb = msm_pkg::WORD_W'(total[msm_pkg::LIMB_BITS-1:0]);
    r.too_long = overflowed;
    product_q.push_back(r);
    if (it.last) begin
      r = '0;
      r.out_limb = carry_acc;
      r.last_out = 1'b1;
      r.too_long = overflowed;
      if (!overflowed) begin
        len = (carry_acc != '0) ? limbs_taken + 1'b1 : extent_nz;
        r.result_length = len;
        r.result_sign = (len == '0) ? '0 : it.sign_tag;
      end
      product_q.push_back(r);
      carry_acc = '0;
      limbs_taken = '0;
      extent_nz = '0;
      overflowed = 1'b0;
    end
  endtask

  task automatic push_limb(input logic [msm_pkg::LIMB_BITS-1:0] limb,
                           input logic [msm_pkg::SCALAR_W-1:0] scalar,
                           input logic [msm_pkg::WORD_W-1:0] sign_tag, input logic last);
    limb_item_t it;
    it = '{limb: limb, scalar: scalar, sign_tag: sign_tag, last: last};
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, sign_tag, scalar, limb};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_products(it);
    items_sent++;
  endtask

  function automatic logic [msm_pkg::LIMB_BITS-1:0] rand_limb();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 25) return '1;
    return msm_pkg::LIMB_BITS'($urandom);
  endfunction

  function automatic logic [msm_pkg::SCALAR_W-1:0] rand_scalar();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return 32'd1;
    if (pick < 26) return '1;
    return $urandom;
  endfunction

  task automatic send_random_number(input int unsigned n_limbs);
    logic [msm_pkg::SCALAR_W-1:0] scalar;
    int unsigned zero_top;
    scalar = rand_scalar();
    zero_top = ($urandom_range(4) == 0) ? $urandom_range(n_limbs) : 0;
    for (int unsigned i = 0; i < n_limbs; i++) begin
      if ($urandom_range(9) == 0) scalar = rand_scalar();
      push_limb((i >= n_limbs - zero_top) ? '0 : rand_limb(), scalar, $urandom,
                i == n_limbs - 1);
    end
  endtask

  task automatic test_single_limb_numbers();
    push_limb('0, '1, '1, 1'b1);
    push_limb('1, '1, 32'h8000_0001, 1'b1);
    push_limb('1, '0, 32'h1234_5678, 1'b1);
    push_limb(28'd1, 32'd1, '0, 1'b1);
    push_limb('1, 32'd1, 32'hA5A5_A5A5, 1'b1);
    push_limb(28'd1, '1, 32'd1, 1'b1);
  endtask

  task automatic test_trimming_and_carry();
    push_limb('1, 32'd1, 32'd3, 1'b0);
    push_limb('0, 32'd1, 32'd5, 1'b0);
    push_limb('0, 32'd1, 32'd7, 1'b1);
    push_limb('0, 32'd1, '0, 1'b0);
    push_limb('0, 32'd1, '0, 1'b0);
    push_limb(28'd5, 32'd1, 32'h5A5A_5A5A, 1'b1);
    push_limb('0, '1, 32'hFFFF_0000, 1'b0);
    push_limb('0, '1, 32'h0000_FFFF, 1'b1);
    push_limb('1, '1, 32'd11, 1'b0);
    push_limb('1, '1, 32'd22, 1'b0);
    push_limb('1, '1, 32'hC000_0003, 1'b1);
    push_limb(28'h123, 32'd10, 32'd1, 1'b0);
    push_limb(28'h456, '1, 32'd2, 1'b1);
  endtask

  task automatic test_limb_limit();
    for (int i = 0; i < msm_pkg::MAX_LIMBS; i++)
      push_limb('1, '1, 32'h8000_0000, i == msm_pkg::MAX_LIMBS - 1);
    send_random_number(msm_pkg::MAX_LIMBS + 1);
    send_random_number(msm_pkg::MAX_LIMBS + 2);
    for (int i = 0; i < msm_pkg::MAX_LIMBS + 3; i++)
      push_limb('0, '1, '1, i == msm_pkg::MAX_LIMBS + 2);
    send_random_number(3);
  endtask

  task automatic test_random_numbers(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) send_random_number($urandom_range(8, 1));
      else if (pick < 96) send_random_number($urandom_range(40, 9));
      else send_random_number($urandom_range(msm_pkg::MAX_LIMBS + 4,
                                             msm_pkg::MAX_LIMBS - 4));
    end
  endtask

  always @(posedge clk) begin
    msm_pkg::msm_result_t got;
    msm_pkg::msm_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.out_limb      = m_tdata[31:0];
      got.result_length = m_tdata[38:32];
      got.result_sign   = m_tdata[70:39];
      got.last_out      = m_tlast;
      got.too_long      = m_tuser;
      if (product_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected transaction: limb %h last %b len %0d sign %h too_long %b",
                   got.out_limb, got.last_out, got.result_length, got.result_sign,
                   got.too_long);
      end else begin
        want = product_q.pop_front();
        if (got.out_limb !== want.out_limb || got.last_out !== want.last_out ||
            got.result_length !== want.result_length ||
            got.result_sign !== want.result_sign || got.too_long !== want.too_long) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected limb %h last %b len %0d sign %h too_long %b, %s",
                     want.out_limb, want.last_out, want.result_length, want.result_sign,
                     want.too_long,
                     $sformatf("got limb %h last %b len %0d sign %h too_long %b",
                               got.out_limb, got.last_out, got.result_length,
                               got.result_sign, got.too_long));
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 84;
    test_single_limb_numbers();
    test_trimming_and_carry();
    test_limb_limit();
    test_random_numbers(200);
    send_idle_pct = 84;
    recv_idle_pct = 11;
    test_random_numbers(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_numbers(350);
    s_tvalid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
